FILE: rtl/tdds_pkg.sv
`default_nettype none

package tdds_pkg;

  // Default number of touch slots.
  localparam int MAX_TOUCHES_DEF = 16;

  // Request codes of an input item.
  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_AREA_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_AREA_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_WIDTH_RATIO  = 3'd2;
  localparam logic [2:0] CFG_DEAD_ZONE    = 3'd3;
  localparam logic [2:0] CFG_UP_BUTTON    = 3'd4;
  localparam logic [2:0] CFG_DOWN_BUTTON  = 3'd5;
  localparam logic [2:0] CFG_LEFT_BUTTON  = 3'd6;
  localparam logic [2:0] CFG_RIGHT_BUTTON = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Ratio limits and reset values.
  localparam logic [8:0] RATIO_MIN   = 9'd26;
  localparam logic [8:0] RATIO_MAX   = 9'd256;
  localparam logic [8:0] RATIO_RESET = 9'd85;
  localparam logic [6:0] UP_RESET    = 7'd12;
  localparam logic [6:0] DOWN_RESET  = 7'd13;
  localparam logic [6:0] LEFT_RESET  = 7'd14;
  localparam logic [6:0] RIGHT_RESET = 7'd15;

  // Squared sine of the arm half angle, scaled by 65536.
  localparam logic [17:0] SIN2_NUM = 18'd9597;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = 49;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  touch_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [6:0] button_index;
    logic       now_held;
    logic       last_event;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/tdds_ram.sv
`default_nettype none

module tdds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/touch_dpad_direction_socd_core.sv
`default_nettype none

// Touch d-pad direction decoder. Each item sets, removes or clears touches,
// after which the block rescans all touch slots through one shared multiplier
// and reports every direction that changed, up, down, left, right in that
// order, one event per cycle on out_strobe; the receiver cannot stall, so
// events must be taken as they appear. busy is high from the cycle after
// start until the events are out. The sequencer first sets the deadzone,
// then scans every slot: an empty slot is skipped, a touch is loaded and
// tested against the deadzone, and a touch outside it goes on through its
// squares, their sum and the sector bound, which takes three passes through
// the multiplier. Each event shows on out_strobe in the cycle after the
// sequencer issues it, so the last one appears in the first cycle with busy
// low. An item with the unused request code is taken without effect and
// leaves busy low.

module touch_dpad_direction_socd_core
  import tdds_pkg::*;
#(
  parameter int MAX_TOUCHES = MAX_TOUCHES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_strobe,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_AW = $clog2(MAX_TOUCHES);
  localparam int CNT_W   = $clog2(MAX_TOUCHES + 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DZ_MUL = 4'd1;
  localparam logic [3:0] ST_DZ_MAX = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_LOAD   = 4'd4;
  localparam logic [3:0] ST_SQX    = 4'd5;
  localparam logic [3:0] ST_SQY    = 4'd6;
  localparam logic [3:0] ST_SUM    = 4'd7;
  localparam logic [3:0] ST_RHS    = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;
  localparam logic [3:0] ST_EMIT   = 4'd11;

  // Direction bits.
  localparam int VOTE_UP    = 0;
  localparam int VOTE_DOWN  = 1;
  localparam int VOTE_LEFT  = 2;
  localparam int VOTE_RIGHT = 3;

  // Configuration registers.
  logic [15:0] width_r, height_r, dead_zone_r;
  logic [8:0]  ratio_r;
  logic [6:0]  up_r, down_r, left_r, right_r;

  // Control state.
  logic [3:0]             state_r, state_nxt;
  logic [MAX_TOUCHES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [3:0]             votes_r, votes_nxt;
  logic [3:0]             dir_r, dir_nxt;
  logic [3:0]             changed_r, changed_nxt;
  logic                   out_strobe_r, out_strobe_nxt;

  // Datapath registers.
  logic [PROD_W-1:0] prod_r;
  logic [24:0]       dz_r, dz_nxt;
  logic [16:0]       dxa_r, dya_r, dxa_nxt, dya_nxt;
  logic              dxn_r, dyn_r, dxn_nxt, dyn_nxt;
  logic [33:0]       dx2_r, dy2_r, dx2_nxt, dy2_nxt;
  logic [34:0]       len2_r, len2_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // Slot table and shared multiplier.
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [15:0]        minside;
  logic               accept, id_ok;

  assign accept    = start && (state_r == ST_IDLE);
  assign id_ok     = int'(in_item.touch_id) < MAX_TOUCHES;
  assign ram_we    = accept && (in_item.req_type == REQ_SET) && id_ok;
  assign ram_waddr = SLOT_AW'(in_item.touch_id);
  assign ram_raddr = idx_r[SLOT_AW-1:0];
  assign minside   = (width_r < height_r) ? width_r : height_r;

  tdds_ram #(
    .WIDTH (32),
    .DEPTH (MAX_TOUCHES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_item.pos_x, in_item.pos_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DZ_MUL: begin
        mul_a = MUL_A_W'(minside);
        mul_b = MUL_B_W'(ratio_r);
      end
      ST_SQX: begin
        mul_a = MUL_A_W'(dxa_r);
        mul_b = MUL_B_W'(dxa_r);
      end
      ST_SQY: begin
        mul_a = MUL_A_W'(dya_r);
        mul_b = MUL_B_W'(dya_r);
      end
      ST_RHS: begin
        mul_a = len2_r;
        mul_b = SIN2_NUM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    logic [17:0] dx_full, dy_full;
    logic [17:0] dx_abs, dy_abs;
    logic [24:0] dz_a;
    logic [24:0] dz_b;
    logic        outside;
    logic [49:0] rhs, lhs_x, lhs_y;
    logic [3:0]  votes_fin;
    logic [6:0]  btn [4];
    logic [1:0]  sel;

    state_nxt      = state_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    votes_nxt      = votes_r;
    dir_nxt        = dir_r;
    changed_nxt    = changed_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    dz_nxt         = dz_r;
    dxa_nxt        = dxa_r;
    dya_nxt        = dya_r;
    dxn_nxt        = dxn_r;
    dyn_nxt        = dyn_r;
    dx2_nxt        = dx2_r;
    dy2_nxt        = dy2_r;
    len2_nxt       = len2_r;

    // Offsets from the center in doubled units.
    dx_full = {1'b0, ram_rdata[31:16], 1'b0} - {2'b00, width_r};
    dy_full = {1'b0, ram_rdata[15:0], 1'b0} - {2'b00, height_r};
    dx_abs  = dx_full[17] ? (18'd0 - dx_full) : dx_full;
    dy_abs  = dy_full[17] ? (18'd0 - dy_full) : dy_full;

    dz_a    = {dead_zone_r, 9'd0};
    dz_b    = prod_r[24:0];
    outside = ({dxa_r, 8'd0} > dz_r) || ({dya_r, 8'd0} > dz_r);

    rhs   = {1'b0, prod_r};
    lhs_x = {dx2_r, 16'd0};
    lhs_y = {dy2_r, 16'd0};

    // Opposing votes cancel.
    votes_fin = votes_r;
    if (votes_r[VOTE_UP] && votes_r[VOTE_DOWN]) begin
      votes_fin[VOTE_UP]   = 1'b0;
      votes_fin[VOTE_DOWN] = 1'b0;
    end
    if (votes_r[VOTE_LEFT] && votes_r[VOTE_RIGHT]) begin
      votes_fin[VOTE_LEFT]  = 1'b0;
      votes_fin[VOTE_RIGHT] = 1'b0;
    end

    btn[VOTE_UP]    = up_r;
    btn[VOTE_DOWN]  = down_r;
    btn[VOTE_LEFT]  = left_r;
    btn[VOTE_RIGHT] = right_r;
    sel = '0;
    for (int d = 3; d >= 0; d--) begin
      if (changed_r[d]) begin
        sel = 2'(d);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          votes_nxt = '0;
          case (in_item.req_type)
            REQ_SET: begin
              if (id_ok) begin
                valid_nxt[SLOT_AW'(in_item.touch_id)] = 1'b1;
              end
              state_nxt = ST_DZ_MUL;
            end
            REQ_REMOVE: begin
              if (id_ok) begin
                valid_nxt[SLOT_AW'(in_item.touch_id)] = 1'b0;
              end
              state_nxt = ST_DZ_MUL;
            end
            REQ_CLEAR: begin
              valid_nxt = '0;
              state_nxt = ST_DZ_MUL;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DZ_MUL: begin
        state_nxt = ST_DZ_MAX;
      end
      ST_DZ_MAX: begin
        dz_nxt    = (dz_a > dz_b) ? dz_a : dz_b;
        state_nxt = ST_SCAN;
      end
      // Walk the slots; empty ones are skipped without a load.
      ST_SCAN: begin
        if (int'(idx_r) == MAX_TOUCHES) begin
          state_nxt = ST_FIN;
        end else if (valid_r[idx_r[SLOT_AW-1:0]]) begin
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_LOAD: begin
        dxa_nxt   = dx_abs[16:0];
        dya_nxt   = dy_abs[16:0];
        dxn_nxt   = dx_full[17];
        dyn_nxt   = dy_full[17];
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        if (outside) begin
          state_nxt = ST_SQY;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SQY: begin
        dx2_nxt   = prod_r[33:0];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        dy2_nxt   = prod_r[33:0];
        len2_nxt  = {1'b0, dx2_r} + {1'b0, prod_r[33:0]};
        state_nxt = ST_RHS;
      end
      ST_RHS: begin
        state_nxt = ST_CMP;
      end
      // Angle test against the arm sector on each axis.
      ST_CMP: begin
        if (lhs_y > rhs) begin
          if (dyn_r) begin
            votes_nxt[VOTE_UP] = 1'b1;
          end else begin
            votes_nxt[VOTE_DOWN] = 1'b1;
          end
        end
        if (lhs_x > rhs) begin
          if (dxn_r) begin
            votes_nxt[VOTE_LEFT] = 1'b1;
          end else begin
            votes_nxt[VOTE_RIGHT] = 1'b1;
          end
        end
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = ST_SCAN;
      end
      ST_FIN: begin
        changed_nxt = votes_fin ^ dir_r;
        dir_nxt     = votes_fin;
        state_nxt   = ST_EMIT;
      end
      // One event per cycle, lowest changed direction first.
      ST_EMIT: begin
        if (changed_r == 4'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          changed_nxt[sel]          = 1'b0;
          out_strobe_nxt            = 1'b1;
          out_item_nxt.button_index = btn[sel];
          out_item_nxt.now_held     = dir_r[sel];
          out_item_nxt.last_event   = (changed_nxt == 4'd0);
          if (changed_nxt == 4'd0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      idx_r        <= '0;
      votes_r      <= '0;
      dir_r        <= '0;
      changed_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      idx_r        <= idx_nxt;
      votes_r      <= votes_nxt;
      dir_r        <= dir_nxt;
      changed_r    <= changed_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r     <= PROD_W'(mul_a) * PROD_W'(mul_b);
    dz_r       <= dz_nxt;
    dxa_r      <= dxa_nxt;
    dya_r      <= dya_nxt;
    dxn_r      <= dxn_nxt;
    dyn_r      <= dyn_nxt;
    dx2_r      <= dx2_nxt;
    dy2_r      <= dy2_nxt;
    len2_r     <= len2_nxt;
    out_item_r <= out_item_nxt;
  end

  // Configuration registers; the ratio saturates on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= '0;
      height_r    <= '0;
      ratio_r     <= RATIO_RESET;
      dead_zone_r <= '0;
      up_r        <= UP_RESET;
      down_r      <= DOWN_RESET;
      left_r      <= LEFT_RESET;
      right_r     <= RIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AREA_WIDTH:  width_r     <= cfg_wdata;
        CFG_AREA_HEIGHT: height_r    <= cfg_wdata;
        CFG_WIDTH_RATIO: begin
          if (cfg_wdata[8:0] < RATIO_MIN) begin
            ratio_r <= RATIO_MIN;
          end else if (cfg_wdata[8:0] > RATIO_MAX) begin
            ratio_r <= RATIO_MAX;
          end else begin
            ratio_r <= cfg_wdata[8:0];
          end
        end
        CFG_DEAD_ZONE:    dead_zone_r <= cfg_wdata;
        CFG_UP_BUTTON:    up_r        <= cfg_wdata[6:0];
        CFG_DOWN_BUTTON:  down_r      <= cfg_wdata[6:0];
        CFG_LEFT_BUTTON:  left_r      <= cfg_wdata[6:0];
        CFG_RIGHT_BUTTON: right_r     <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

FILE: rtl/tdds_checker.sv
`default_nettype none

module tdds_checker
  import tdds_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);

  // A real request keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type != REQ_NONE) |=> busy)
    else $error("block not busy after a request item");

  // An unused request code does nothing at all.
  a_none_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type == REQ_NONE) |=> (!busy && !out_strobe))
    else $error("unused request code had an effect");

  // Events of one item come back to back and end with the last marker.
  a_events_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last_event) |=> out_strobe)
    else $error("gap inside an event burst");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_event) |=> !out_strobe)
    else $error("event after the last event of an item");

  // No event may appear while the block is idle, except the final one draining.
  a_no_idle_events: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !busy) |-> out_item.last_event)
    else $error("event shown while idle");

endmodule

bind touch_dpad_direction_socd_core tdds_checker u_tdds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire
